@@ rtl/core/dng_pkg.sv @@
// dng_pkg: shared types and constants of the dither noise generator
// generator constants, method and format codes, register indexes, multiplier widths
// no dependencies
package dng_pkg;

  // linear congruential generator
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;

  // 2^32 / sqrt(6), rounded
  localparam logic [31:0] INV_SQRT6_Q32 = 32'd1753413056;

  // window of raw values: current one plus the lookahead
  localparam int LOOKAHEAD = 2;
  localparam int WIN_SIZE  = LOOKAHEAD + 1;
  localparam int RAW_W     = 34;
  localparam logic signed [RAW_W-1:0] RECT_OFFSET = 34'sh0_8000_0000;

  // dither method codes, the unused code behaves as triangular
  localparam logic [1:0] METHOD_RECT   = 2'd0;
  localparam logic [1:0] METHOD_TRI    = 2'd1;
  localparam logic [1:0] METHOD_TRI_HP = 2'd2;

  // output formats
  localparam logic FORMAT_S16 = 1'b0;
  localparam logic FORMAT_S32 = 1'b1;

  // register indexes
  localparam int REG_INDEX_W = 2;
  localparam logic [REG_INDEX_W-1:0] REG_DITHER_METHOD = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_OUTPUT_FORMAT = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_NOISE_SCALE   = 2'd2;

  localparam int SCALE_W = 56;
  localparam int CFG_DATA_W = 56;

  // serial multiplier: a times b, one 16-bit digit of b per cycle
  localparam int MUL_A_W     = 66;
  localparam int MUL_B_W     = 64;
  localparam int MUL_DIGIT_W = 16;
  localparam int MUL_DIGITS  = MUL_B_W / MUL_DIGIT_W;
  localparam int MUL_ACC_W   = MUL_A_W + MUL_DIGIT_W;
  localparam int PROD_W      = 128;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        restart;
    logic [31:0] seed;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         dither_method;
    logic               output_format;
    logic [SCALE_W-1:0] scale_factor;
  } cfg_t;

endpackage

@@ rtl/core/dng_front.sv @@
// dng_front: accepts requests, classifies them and queues them for the back end
// depends on dng_pkg
module dng_front import dng_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        kind,
  input  logic [31:0] seed,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign req_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr].restart <= kind;
      queue[wr_ptr].seed    <= seed;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("request queue over depth");

endmodule

@@ rtl/core/dng_mul.sv @@
// dng_mul: serial multiplier, one 16-bit digit of the multiplier per cycle
// depends on dng_pkg
module dng_mul import dng_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [PROD_W-1:0]  product
);

  localparam int CNT_W = (MUL_DIGITS > 1) ? $clog2(MUL_DIGITS) : 1;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [MUL_A_W-1:0]   a_reg;
  logic [MUL_B_W-1:0]   b_reg;
  logic [MUL_ACC_W-1:0] hi;
  logic [MUL_B_W-1:0]   lo;
  logic [MUL_ACC_W-1:0] pp;
  logic [MUL_ACC_W-1:0] sum;

  assign pp      = MUL_ACC_W'(a_reg) * MUL_ACC_W'(b_reg[MUL_DIGIT_W-1:0]);
  assign sum     = hi + pp;
  assign product = {hi[PROD_W-MUL_B_W-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(MUL_DIGITS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath, low digit retires into lo each cycle while busy
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= b;
      hi    <= '0;
      lo    <= '0;
    end else if (busy) begin
      b_reg <= b_reg >> MUL_DIGIT_W;
      hi    <= sum >> MUL_DIGIT_W;
      lo    <= {sum[MUL_DIGIT_W-1:0], lo[MUL_B_W-1:MUL_DIGIT_W]};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("multiplier restarted while busy");

endmodule

@@ rtl/core/dng_back.sv @@
// dng_back: generator, raw value window, scaling and saturation of one sample
// depends on dng_pkg and dng_mul
module dng_back import dng_pkg::*; #(
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [31:0] noise_sample,
  output logic               saturated
);

  localparam int SH_PLAIN = 32 + SCALE_FRAC_BITS;
  localparam int SH_HP    = SH_PLAIN + 32;
  localparam int DRAW_W   = $clog2(WIN_SIZE + 1);
  localparam int V_W      = RAW_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_DRAW_A, S_DRAW_B, S_PREP, S_MUL1, S_MUL2, S_FIN
  } state_t;

  state_t                   state;
  logic [31:0]              gen;
  logic [31:0]              draw_a;
  logic [DRAW_W-1:0]        draws_left;
  logic signed [RAW_W-1:0]  window [WIN_SIZE];
  logic                     neg;
  logic                     mul_start;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic                     mul_done;
  logic [PROD_W-1:0]        mul_product;

  logic [31:0]              lcg_val;
  logic signed [RAW_W-1:0]  raw_new;
  logic                     is_rect;
  logic                     is_hp;
  logic signed [V_W-1:0]    w0x;
  logic signed [V_W-1:0]    w1x;
  logic signed [V_W-1:0]    w2x;
  logic signed [V_W-1:0]    v;
  logic [V_W-1:0]           v_mag;
  logic [PROD_W-1:0]        q;
  logic [31:0]              lim;
  logic                     over;
  logic [31:0]              m;

  assign cmd_ready = (state == S_IDLE);
  assign is_rect   = (cfg.dither_method == METHOD_RECT);
  assign is_hp     = (cfg.dither_method == METHOD_TRI_HP);

  assign lcg_val = gen * LCG_MUL + LCG_INC;
  assign raw_new = (state == S_DRAW_B)
                   ? $signed({2'b00, draw_a}) - $signed({2'b00, lcg_val})
                   : $signed({2'b00, lcg_val}) - RECT_OFFSET;

  // high-pass: 2*w1 - w0 - w2
  assign w0x   = V_W'(window[0]);
  assign w1x   = V_W'(window[1]);
  assign w2x   = V_W'(window[2]);
  assign v     = is_hp ? (w1x <<< 1) - w0x - w2x : w0x;
  assign v_mag = v[V_W-1] ? V_W'(-v) : V_W'(v);

  // truncate toward zero on the magnitude, then clip
  assign q = is_hp ? (mul_product >> SH_HP) : (mul_product >> SH_PLAIN);
  always_comb begin
    if (cfg.output_format == FORMAT_S32) begin
      lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      lim = neg ? 32'h0000_8000 : 32'h0000_7FFF;
    end
  end
  assign over = (|q[PROD_W-1:32]) || (q[31:0] > lim);
  assign m    = over ? lim : q[31:0];

  dng_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gen        <= '0;
      rsp_valid  <= 1'b0;
      mul_start  <= 1'b0;
      draws_left <= '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
        window[i] <= '0;
      end
    end else begin
      mul_start <= (state == S_PREP) || (state == S_MUL1 && mul_done);
      if (state == S_FIN && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.restart) begin
              gen        <= cmd.seed;
              draws_left <= DRAW_W'(WIN_SIZE);
            end else begin
              draws_left <= DRAW_W'(1);
            end
            state <= S_DRAW_A;
          end
        end
        S_DRAW_A: begin
          gen <= lcg_val;
          if (is_rect) begin
            for (int i = 0; i < WIN_SIZE - 1; i++) begin
              window[i] <= window[i+1];
            end
            window[WIN_SIZE-1] <= raw_new;
            draws_left <= draws_left - DRAW_W'(1);
            state <= (draws_left == DRAW_W'(1)) ? S_PREP : S_DRAW_A;
          end else begin
            draw_a <= lcg_val;
            state  <= S_DRAW_B;
          end
        end
        S_DRAW_B: begin
          gen <= lcg_val;
          for (int i = 0; i < WIN_SIZE - 1; i++) begin
            window[i] <= window[i+1];
          end
          window[WIN_SIZE-1] <= raw_new;
          draws_left <= draws_left - DRAW_W'(1);
          state <= (draws_left == DRAW_W'(1)) ? S_PREP : S_DRAW_A;
        end
        S_PREP: begin
          neg   <= v[V_W-1];
          mul_a <= MUL_A_W'(v_mag);
          mul_b <= is_hp ? MUL_B_W'(INV_SQRT6_Q32) : MUL_B_W'(cfg.scale_factor);
          state <= is_hp ? S_MUL1 : S_MUL2;
        end
        S_MUL1: begin
          if (mul_done) begin
            mul_a <= mul_product[MUL_A_W-1:0];
            mul_b <= MUL_B_W'(cfg.scale_factor);
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            noise_sample <= neg ? $signed(-m) : $signed(m);
            saturated    <= over;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MUL1 || state == S_MUL2))
    else $error("product ready outside a multiply state");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FIN)
    else $error("result loaded outside the final step");

endmodule

@@ rtl/core/dither_noise_generator_unit.sv @@
// dither_noise_generator_unit: top level, configuration registers and the two halves
// depends on dng_pkg, dng_front, dng_back (and dng_mul below it)
//
// Usage: each request on req_* (kind, seed) gives exactly one result on rsp_*
// (noise_sample, saturated). kind 1 reseeds the generator and refills the
// three-entry window; kind 0 shifts the window and draws one new raw value.
// Both channels are valid/ready. A two-entry queue sits behind req_ready, so
// requests are taken while the back end works or waits on rsp_ready.
// Configuration is written through cfg_write/cfg_index/cfg_data while no
// request is outstanding; an index beyond the register list is ignored.
// Throughput: one request at a time in the back end. Each request runs one
// generator step per cycle (one or two per raw value, three raw values on a
// restart) and then the serial multiplier, four 16-bit digits per pass, with
// a second pass in triangular high-pass mode.
// Reset: registers take their reset values, generator state and window are
// cleared, queue and result register are emptied. A stalled receiver holds the
// result in place; the back end then waits and the queue fills.
module dither_noise_generator_unit import dng_pkg::*; #(
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic                   kind,
  input  logic [31:0]            seed,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output logic signed [31:0]     noise_sample,
  output logic                   saturated,
  input  logic                   cfg_write,
  input  logic [REG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dither_method <= METHOD_TRI;
      cfg.output_format <= FORMAT_S16;
      cfg.scale_factor  <= SCALE_W'(1) << SCALE_FRAC_BITS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DITHER_METHOD: cfg.dither_method <= cfg_data[1:0];
        REG_OUTPUT_FORMAT: cfg.output_format <= cfg_data[0];
        REG_NOISE_SCALE:   cfg.scale_factor  <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dng_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .kind      (kind),
    .seed      (seed),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dng_back #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .cfg          (cfg),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .noise_sample (noise_sample),
    .saturated    (saturated)
  );

endmodule
